@@ rtl/sfl_pkg.sv @@
// shared types, constants and helpers for the per-source syn flood limiter
// no dependencies
package sfl_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 256;

  localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
  localparam logic [7:0]  PROTO_TCP       = 8'd6;
  localparam logic [15:0] MIN_TCP_FRAME   = 16'd54;
  localparam logic [31:0] THRESHOLD_RESET = 32'd100;
  localparam logic [31:0] COUNT_MAX       = 32'hFFFF_FFFF;
  localparam logic [31:0] COUNT_FIRST     = 32'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_HIT,
    RES_NEW,
    RES_FULL
  } res_kind_t;

  typedef struct packed {
    logic [31:0] source;
    logic [31:0] count;
  } entry_t;

  typedef struct packed {
    logic      capture;
    logic      scan_step;
    logic      latch_hit;
    logic      wr_update;
    logic      insert;
    logic      set_kind;
    res_kind_t kind;
    logic      load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic qual;
    logic hit;
    logic scan_done;
    logic full;
    logic out_free;
  } ctl_sts_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + 32'd1;
  endfunction

endpackage

@@ rtl/sfl_ram.sv @@
// generic single write port ram with registered read
// no dependencies
module sfl_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/sfl_dp.sv @@
// datapath: beat capture, table scan over the entry ram, counter update, result register
// depends on sfl_pkg and sfl_ram
module sfl_dp #(
  parameter int unsigned TABLE_ENTRIES = sfl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sfl_pkg::ctl_cmd_t   cmd,
  output sfl_pkg::ctl_sts_t   sts,
  input  logic                cfg_write_en,
  input  logic [31:0]         cfg_syn_threshold,
  input  logic [15:0]         in_packet_length,
  input  logic [15:0]         in_ether_type,
  input  logic [7:0]          in_ip_protocol,
  input  logic                in_tcp_syn,
  input  logic                in_tcp_ack,
  input  logic [31:0]         in_source_address,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_drop_packet,
  output logic                out_syn_counted,
  output logic [31:0]         out_source_syn_total,
  output logic                out_table_full
);

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned UW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned EW = $bits(sfl_pkg::entry_t);

  logic [31:0]        thr_r;
  logic [31:0]        src_r;
  logic               qual_r;
  logic [UW-1:0]      used_r;
  logic [UW-1:0]      scan_r;
  logic               pend_r;
  logic [AW-1:0]      pend_idx_r;
  logic [AW-1:0]      slot_r;
  logic [31:0]        count_r;
  sfl_pkg::res_kind_t kind_r;

  logic               out_valid_r;
  logic               out_drop_r;
  logic               out_counted_r;
  logic [31:0]        out_total_r;
  logic               out_full_r;

  logic               in_qual;
  logic               issue;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  sfl_pkg::entry_t    ram_wdata;
  sfl_pkg::entry_t    ram_rdata;
  logic [EW-1:0]      ram_rbits;

  assign in_qual = (in_packet_length >= sfl_pkg::MIN_TCP_FRAME)
                && (in_ether_type == sfl_pkg::ETHERTYPE_IPV4)
                && (in_ip_protocol == sfl_pkg::PROTO_TCP)
                && in_tcp_syn && !in_tcp_ack;

  assign issue = cmd.scan_step && (scan_r < used_r);

  always_comb begin
    ram_we    = cmd.wr_update || cmd.insert;
    ram_waddr = cmd.insert ? used_r[AW-1:0] : slot_r;
    ram_wdata.source = src_r;
    ram_wdata.count  = cmd.insert ? sfl_pkg::COUNT_FIRST : count_r;
  end

  sfl_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_r[AW-1:0]),
    .rdata (ram_rbits)
  );

  assign ram_rdata = sfl_pkg::entry_t'(ram_rbits);

  always_comb begin
    sts.qual      = qual_r;
    sts.hit       = pend_r && (ram_rdata.source == src_r);
    sts.scan_done = !pend_r && (scan_r == used_r);
    sts.full      = (used_r == UW'(TABLE_ENTRIES));
    sts.out_free  = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= sfl_pkg::THRESHOLD_RESET;
      used_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        thr_r <= cfg_syn_threshold;
      end
      if (cmd.insert) begin
        used_r <= used_r + UW'(1);
      end
      if (cmd.capture) begin
        pend_r <= 1'b0;
      end else if (cmd.scan_step) begin
        pend_r <= issue;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      src_r  <= in_source_address;
      qual_r <= in_qual;
      scan_r <= '0;
    end else if (issue) begin
      scan_r <= scan_r + UW'(1);
    end
    if (cmd.scan_step) begin
      pend_idx_r <= scan_r[AW-1:0];
    end
    if (cmd.latch_hit) begin
      count_r <= sfl_pkg::sat_inc(ram_rdata.count);
      slot_r  <= pend_idx_r;
    end
    if (cmd.set_kind) begin
      kind_r <= cmd.kind;
    end
    if (cmd.load_out) begin
      unique case (kind_r)
        sfl_pkg::RES_HIT: begin
          out_drop_r    <= (count_r > thr_r);
          out_counted_r <= 1'b1;
          out_total_r   <= count_r;
          out_full_r    <= 1'b0;
        end
        sfl_pkg::RES_NEW: begin
          out_drop_r    <= 1'b0;
          out_counted_r <= 1'b1;
          out_total_r   <= sfl_pkg::COUNT_FIRST;
          out_full_r    <= 1'b0;
        end
        sfl_pkg::RES_FULL: begin
          out_drop_r    <= 1'b0;
          out_counted_r <= 1'b0;
          out_total_r   <= '0;
          out_full_r    <= 1'b1;
        end
        default: begin
          out_drop_r    <= 1'b0;
          out_counted_r <= 1'b0;
          out_total_r   <= '0;
          out_full_r    <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_drop_packet      = out_drop_r;
  assign out_syn_counted      = out_counted_r;
  assign out_source_syn_total = out_total_r;
  assign out_table_full       = out_full_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |=> used_r == $past(used_r) + UW'(1))
    else $error("insert did not advance fill count");

  a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |-> !sts.full)
    else $error("insert into full table");

  a_drop_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_drop_r || out_counted_r) && !(out_counted_r && out_full_r))
    else $error("inconsistent result flags");

endmodule

@@ rtl/sfl_ctl.sv @@
// controller state machine: sequences capture, scan, update and result hand-off
// depends on sfl_pkg
module sfl_ctl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sfl_pkg::ctl_sts_t sts,
  output sfl_pkg::ctl_cmd_t cmd
);

  sfl_pkg::state_t state_r;
  sfl_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.kind  = sfl_pkg::RES_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      sfl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = sfl_pkg::ST_SCAN;
        end
      end
      sfl_pkg::ST_SCAN: begin
        priority if (!sts.qual) begin
          cmd.set_kind = 1'b1;
          cmd.kind     = sfl_pkg::RES_NONE;
          state_nxt    = sfl_pkg::ST_OUT;
        end else if (sts.hit) begin
          cmd.latch_hit = 1'b1;
          state_nxt     = sfl_pkg::ST_UPD;
        end else if (sts.scan_done) begin
          cmd.set_kind = 1'b1;
          if (sts.full) begin
            cmd.kind = sfl_pkg::RES_FULL;
          end else begin
            cmd.kind   = sfl_pkg::RES_NEW;
            cmd.insert = 1'b1;
          end
          state_nxt = sfl_pkg::ST_OUT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      sfl_pkg::ST_UPD: begin
        cmd.wr_update = 1'b1;
        cmd.set_kind  = 1'b1;
        cmd.kind      = sfl_pkg::RES_HIT;
        state_nxt     = sfl_pkg::ST_OUT;
      end
      sfl_pkg::ST_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = sfl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sfl_pkg::ST_IDLE;
      end
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == sfl_pkg::ST_SCAN)
    else $error("accepted beat did not start a scan");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over a waiting beat");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.insert && cmd.wr_update))
    else $error("two table writes in one cycle");

endmodule

@@ rtl/syn_flood_source_limiter_core.sv @@
// top level of the per-source syn flood limiter
// depends on sfl_pkg, sfl_ctl, sfl_dp (and sfl_ram through sfl_dp)
//
// One packet summary is taken at a time. A packet that is not an IPv4 TCP
// SYN without ACK of at least 54 bytes gives an all-zero result, and the
// next beat can be taken in the same cycle as that result appears. A
// qualifying SYN is looked up by reading the source table ram one entry a
// cycle in fill order. The scan stops at the first match, or on a miss
// once all filled entries are read, at most TABLE_ENTRIES; an empty table
// is not read. The next beat can be taken in the cycle after the result
// is loaded. Entries fill in slot order and are tracked by a fill count,
// so there is no clearing pass after reset. The result sits in an output
// register, and the next beat is taken while it waits; that next result
// is held back until the register is free. The threshold may be written
// at any idle time and applies to the next packet.
module syn_flood_source_limiter_core #(
  parameter int unsigned TABLE_ENTRIES = sfl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [31:0] cfg_syn_threshold,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_packet_length,
  input  logic [15:0] in_ether_type,
  input  logic [7:0]  in_ip_protocol,
  input  logic        in_tcp_syn,
  input  logic        in_tcp_ack,
  input  logic [31:0] in_source_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_drop_packet,
  output logic        out_syn_counted,
  output logic [31:0] out_source_syn_total,
  output logic        out_table_full
);

  sfl_pkg::ctl_cmd_t cmd;
  sfl_pkg::ctl_sts_t sts;

  sfl_ctl u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sfl_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_write_en         (cfg_write_en),
    .cfg_syn_threshold    (cfg_syn_threshold),
    .in_packet_length     (in_packet_length),
    .in_ether_type        (in_ether_type),
    .in_ip_protocol       (in_ip_protocol),
    .in_tcp_syn           (in_tcp_syn),
    .in_tcp_ack           (in_tcp_ack),
    .in_source_address    (in_source_address),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_drop_packet      (out_drop_packet),
    .out_syn_counted      (out_syn_counted),
    .out_source_syn_total (out_source_syn_total),
    .out_table_full       (out_table_full)
  );

endmodule
